@@ hw/rtl/mixer_lift_sequencer_defines.svh @@
// assertion macros used by mls_core
`ifndef MIXER_LIFT_SEQUENCER_DEFINES_SVH
`define MIXER_LIFT_SEQUENCER_DEFINES_SVH

// condition implies consequence on the same edge
`define MLS_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence on the next edge
`define MLS_ASSERT_NXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/mls_pkg.sv @@
package mls_pkg;

  localparam int TIMER_BITS = 17;
  localparam int REG_W      = 16;
  localparam int SECS_W     = 8;
  localparam int PROD_W     = 18;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [TIMER_BITS-1:0] CNT_MAX = '1;
  localparam logic [9:0]            MS_PER_S = 10'd1000;

  localparam logic [REG_W-1:0] MIN_MIX_RST     = 16'd500;
  localparam logic [REG_W-1:0] MAX_MIX_RST     = 16'd5000;
  localparam logic [REG_W-1:0] DEFAULT_MIX_RST = 16'd2000;
  localparam logic [REG_W-1:0] TIMEOUT_RST     = 16'd3000;
  localparam logic [REG_W-1:0] MIX_DUR_RST     = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_MIX     = 2'd0,
    REG_MAX_MIX     = 2'd1,
    REG_DEFAULT_MIX = 2'd2,
    REG_TIMEOUT     = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DRV_STOP = 2'd0,
    DRV_UP   = 2'd1,
    DRV_DOWN = 2'd2
  } drive_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_DOWN = 4'b0010,
    PH_MIX  = 4'b0100,
    PH_UP   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [REG_W-1:0] min_mix_ms;
    logic [REG_W-1:0] max_mix_ms;
    logic [REG_W-1:0] default_mix_ms;
    logic [REG_W-1:0] move_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic              cmd;
    logic              has_seconds;
    logic [SECS_W-1:0] start_seconds;
    logic              at_top;
    logic              at_bottom;
    logic              button_pressed;
  } item_t;

  typedef struct packed {
    drive_t motor_drive;
    logic   mixer_on;
    logic   led_on;
    logic   busy_res;
    logic   success;
  } result_t;

endpackage

@@ hw/rtl/mixer_lift_sequencer.sv @@
// channel   dir  tdata (low bit up)                                    tuser
// s_*       in   has_seconds, start_seconds[7:0], at_top, at_bottom,  cmd
//                button_pressed, zero pad to 16
// m_*       out  motor_drive[1:0], mixer_on, led_on, busy_res,        -
//                success, zero pad to 8
// cfg_*     in   write enable, register index, 16-bit write data
// one beat per cycle sustained while the output is not stalled; a taken beat
// passes the input register, then the state update into the result register
// rst clears the pipeline valids and the sequencer state; no clearing pass
// a stalled result holds in the output register while the input register
// still takes one more beat
module mixer_lift_sequencer
  import mls_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // has_seconds, start_seconds, at_top, at_bottom, button_pressed
  input  logic                  s_tuser,   // cmd
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // motor_drive, mixer_on, led_on, busy_res, success
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]      cfg_wdata
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid;
  logic    step;
  result_t res;
  result_t res_q;

  mls_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item_q.cmd            <= s_tuser;
      item_q.has_seconds    <= s_tdata[0];
      item_q.start_seconds  <= s_tdata[8:1];
      item_q.at_top         <= s_tdata[9];
      item_q.at_bottom      <= s_tdata[10];
      item_q.button_pressed <= s_tdata[11];
    end
  end

  mls_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item_q),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_tdata = {2'b00, res_q.success, res_q.busy_res, res_q.led_on,
                    res_q.mixer_on, res_q.motor_drive};

endmodule

@@ hw/rtl/mls_cfg.sv @@
module mls_cfg
  import mls_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_mix_ms      <= MIN_MIX_RST;
      cfg.max_mix_ms      <= MAX_MIX_RST;
      cfg.default_mix_ms  <= DEFAULT_MIX_RST;
      cfg.move_timeout_ms <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_MIN_MIX:     cfg.min_mix_ms      <= cfg_wdata;
        REG_MAX_MIX:     cfg.max_mix_ms      <= cfg_wdata;
        REG_DEFAULT_MIX: cfg.default_mix_ms  <= cfg_wdata;
        REG_TIMEOUT:     cfg.move_timeout_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/mls_core.sv @@
`include "mixer_lift_sequencer_defines.svh"

module mls_core
  import mls_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  phase_t                phase, phase_next;
  logic                  busy_flag, busy_next;
  logic                  error_flag, error_next;
  logic [TIMER_BITS-1:0] tick_count, tick_next;
  logic [REG_W-1:0]      mix_duration, dur_next;

  logic [PROD_W-1:0]     req_ms;
  logic [PROD_W-1:0]     want_ms;
  logic [REG_W-1:0]      clamped_ms;
  logic [REG_W-1:0]      dflt_clamped;
  logic [TIMER_BITS-1:0] tick_inc;
  logic                  timed_out;
  logic                  busy_a;
  drive_t                drive;
  logic                  mixer;

  // clamp in the stated order, so an inverted pair still resolves
  function automatic logic [REG_W-1:0] clamp_ms(input logic [PROD_W-1:0] d,
                                                input logic [REG_W-1:0] lo,
                                                input logic [REG_W-1:0] hi);
    logic [REG_W-1:0] r;
    if (d < PROD_W'(lo))      r = lo;
    else if (d > PROD_W'(hi)) r = hi;
    else                      r = d[REG_W-1:0];
    return r;
  endfunction

  assign req_ms       = PROD_W'(item.start_seconds) * PROD_W'(MS_PER_S);
  assign want_ms      = item.has_seconds ? req_ms : PROD_W'(cfg.default_mix_ms);
  assign clamped_ms   = clamp_ms(want_ms, cfg.min_mix_ms, cfg.max_mix_ms);
  assign dflt_clamped = clamp_ms(PROD_W'(cfg.default_mix_ms), cfg.min_mix_ms,
                                 cfg.max_mix_ms);
  assign tick_inc     = (tick_count == CNT_MAX) ? tick_count : tick_count + 1'b1;
  assign timed_out    = tick_inc > TIMER_BITS'(cfg.move_timeout_ms);

  always_comb begin
    busy_next  = busy_flag;
    error_next = error_flag;
    dur_next   = mix_duration;
    phase_next = phase;
    tick_next  = tick_count;
    drive      = DRV_STOP;
    mixer      = 1'b0;

    if (item.cmd && !busy_flag) begin
      busy_next  = 1'b1;
      error_next = 1'b0;
      dur_next   = clamped_ms;
    end
    busy_a = busy_next;

    unique case (phase)
      PH_IDLE: begin
        tick_next = '0;
        if (busy_a || item.button_pressed) begin
          if (!busy_a) begin
            busy_next  = 1'b1;
            error_next = 1'b0;
            dur_next   = dflt_clamped;
          end
          phase_next = PH_DOWN;
          drive      = DRV_DOWN;
        end else begin
          drive = item.at_top ? DRV_STOP : DRV_UP;
        end
      end
      PH_DOWN: begin
        if (item.at_bottom) begin
          phase_next = PH_MIX;
          tick_next  = '0;
          mixer      = 1'b1;
        end else if (timed_out) begin
          busy_next  = 1'b0;
          error_next = 1'b1;
          phase_next = PH_IDLE;
          tick_next  = '0;
        end else begin
          tick_next = tick_inc;
          drive     = DRV_DOWN;
        end
      end
      PH_MIX: begin
        if (tick_inc >= TIMER_BITS'(mix_duration)) begin
          phase_next = PH_UP;
          tick_next  = '0;
          drive      = DRV_UP;
        end else begin
          tick_next = tick_inc;
          mixer     = 1'b1;
        end
      end
      PH_UP: begin
        if (item.at_top || timed_out) begin
          busy_next  = 1'b0;
          error_next = !item.at_top;
          phase_next = PH_IDLE;
          tick_next  = '0;
        end else begin
          tick_next = tick_inc;
          drive     = DRV_UP;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        busy_next  = 1'b0;
        tick_next  = '0;
      end
    endcase

    res.motor_drive = drive;
    res.mixer_on    = mixer;
    res.led_on      = busy_next;
    res.busy_res    = busy_next;
    res.success     = !error_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      busy_flag    <= 1'b0;
      error_flag   <= 1'b0;
      tick_count   <= '0;
      mix_duration <= MIX_DUR_RST;
    end else if (step) begin
      phase        <= phase_next;
      busy_flag    <= busy_next;
      error_flag   <= error_next;
      tick_count   <= tick_next;
      mix_duration <= dur_next;
    end
  end

  `MLS_ASSERT_IMP(a_busy_phase, clk, rst, 1'b1, busy_flag == (phase != PH_IDLE), "busy and phase disagree")
  `MLS_ASSERT_IMP(a_busy_err, clk, rst, 1'b1, !(busy_flag && error_flag), "busy with error set")
  `MLS_ASSERT_IMP(a_mix_busy, clk, rst, step && res.mixer_on, res.busy_res && res.motor_drive == DRV_STOP, "mixer on outside a cycle")

endmodule

@@ test/mixer_lift_sequencer_tb.sv @@
`timescale 1ns / 1ps

module mixer_lift_sequencer_tb
  import mls_pkg::*;
();

  localparam int unsigned WATCHDOG_LIMIT = 1000;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // has_seconds, start_seconds, at_top, at_bottom, button_pressed
  logic                  s_tuser = 1'b0; // cmd
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // motor_drive, mixer_on, led_on, busy_res, success
  logic                  cfg_we = 1'b0;
  cfg_idx_t              cfg_index = REG_MIN_MIX;
  logic [REG_W-1:0]      cfg_wdata = '0;

  mixer_lift_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // lift sequencer mirror
  cfg_t                  regs_now;
  phase_t                lift_phase;
  logic                  cycle_busy;
  logic                  cycle_err;
  logic [TIMER_BITS-1:0] phase_ticks;
  logic [REG_W-1:0]      mix_len;

  item_t       pending_ticks[$];
  result_t     levels_due[$];
  item_t       on_bus;
  result_t     due_levels;
  int unsigned outstanding = 0;
  int unsigned queued = 0;
  int unsigned errors = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;
  bit          big_mix = 1'b0;

  function automatic void take_start(logic [PROD_W-1:0] d);
    logic [PROD_W-1:0] v;
    v = d;
    if (cycle_busy) return;
    if (v < regs_now.min_mix_ms) v = regs_now.min_mix_ms;
    else if (v > regs_now.max_mix_ms) v = regs_now.max_mix_ms;
    cycle_err = 1'b0;
    cycle_busy = 1'b1;
    mix_len = v[REG_W-1:0];
  endfunction

  function automatic void bump_ticks();
    if (phase_ticks != CNT_MAX) phase_ticks = phase_ticks + 1'b1;
  endfunction

  function automatic void close_cycle(logic err);
    cycle_busy = 1'b0;
    cycle_err = err;
    lift_phase = PH_IDLE;
    phase_ticks = '0;
  endfunction

  function automatic result_t lift_tick(item_t it);
    result_t r;
    drive_t  drv;
    logic    mix;
    logic [PROD_W-1:0] d;
    drv = DRV_STOP;
    mix = 1'b0;
    if (it.has_seconds) d = it.start_seconds * 18'd1000;
    else d = {2'b00, regs_now.default_mix_ms};
    if (it.cmd) take_start(d);
    case (lift_phase)
      PH_IDLE: begin
        if (cycle_busy || it.button_pressed) begin
          take_start({2'b00, regs_now.default_mix_ms});
          lift_phase = PH_DOWN;
          phase_ticks = '0;
          drv = DRV_DOWN;
        end else begin
          phase_ticks = '0;
          if (!it.at_top) drv = DRV_UP;
        end
      end
      PH_DOWN: begin
        if (it.at_bottom) begin
          lift_phase = PH_MIX;
          phase_ticks = '0;
          mix = 1'b1;
        end else begin
          bump_ticks();
          if (phase_ticks > regs_now.move_timeout_ms) close_cycle(1'b1);
          else drv = DRV_DOWN;
        end
      end
      PH_MIX: begin
        bump_ticks();
        if (phase_ticks >= mix_len) begin
          lift_phase = PH_UP;
          phase_ticks = '0;
          drv = DRV_UP;
        end else begin
          mix = 1'b1;
        end
      end
      default: begin
        if (it.at_top) begin
          close_cycle(1'b0);
        end else begin
          bump_ticks();
          if (phase_ticks > regs_now.move_timeout_ms) close_cycle(1'b1);
          else drv = DRV_UP;
        end
      end
    endcase
    r.motor_drive = drv;
    r.mixer_on = mix;
    r.led_on = cycle_busy;
    r.busy_res = cycle_busy;
    r.success = !cycle_err;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic bit rbit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic item_t mk(bit c, bit hs, logic [7:0] secs, bit top, bit bot, bit btn);
    item_t it;
    it.cmd = c;
    it.has_seconds = hs;
    it.start_seconds = secs;
    it.at_top = top;
    it.at_bottom = bot;
    it.button_pressed = btn;
    return it;
  endfunction

  // long second counts are kept out while the clamp allows long mixes
  function automatic item_t noise_item(bit top, bit bot);
    item_t it;
    it.cmd = ($urandom_range(0, 7) == 0);
    it.has_seconds = rbit();
    it.start_seconds = 8'($urandom_range(0, 255));
    if (it.cmd && it.has_seconds && big_mix) it.start_seconds = 8'd0;
    it.at_top = top;
    it.at_bottom = bot;
    it.button_pressed = ($urandom_range(0, 9) == 0);
    return it;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) levels_due.push_back(lift_tick(on_bus));
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          on_bus = pending_ticks.pop_front();
          s_tdata <= {4'b0000, on_bus.button_pressed, on_bus.at_bottom, on_bus.at_top,
                      on_bus.start_seconds, on_bus.has_seconds};
          s_tuser <= on_bus.cmd;
          s_tvalid <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [1:0] want, logic [1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (levels_due.size() == 0) begin
          $error("output beat %h with nothing expected", m_tdata);
          errors++;
        end else begin
          due_levels = levels_due.pop_front();
          outstanding--;
          check_field("motor_drive", due_levels.motor_drive, m_tdata[1:0]);
          check_field("mixer_on", {1'b0, due_levels.mixer_on}, {1'b0, m_tdata[2]});
          check_field("led_on", {1'b0, due_levels.led_on}, {1'b0, m_tdata[3]});
          check_field("busy_res", {1'b0, due_levels.busy_res}, {1'b0, m_tdata[4]});
          check_field("success", {1'b0, due_levels.success}, {1'b0, m_tdata[5]});
        end
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        m_tready <= 1'b1;
        if (m_tvalid && m_tready) stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic put(item_t it);
    pending_ticks.push_back(it);
    outstanding++;
    queued++;
  endtask

  task automatic drain();
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_MIN_MIX:     regs_now.min_mix_ms = val;
      REG_MAX_MIX:     regs_now.max_mix_ms = val;
      REG_DEFAULT_MIX: regs_now.default_mix_ms = val;
      default:         regs_now.move_timeout_ms = val;
    endcase
  endtask

  task automatic set_config(logic [REG_W-1:0] lo, logic [REG_W-1:0] hi,
                            logic [REG_W-1:0] dflt, logic [REG_W-1:0] tmo);
    drain();
    write_reg(REG_MIN_MIX, lo);
    write_reg(REG_MAX_MIX, hi);
    write_reg(REG_DEFAULT_MIX, dflt);
    write_reg(REG_TIMEOUT, tmo);
    @(posedge clk);
    cfg_we <= 1'b0;
    big_mix = (hi > 64) || (lo > 64);
  endtask

  // homing, start, lower, mix, raise, with chatter throughout
  task automatic add_run();
    int unsigned span;
    item_t it;
    span = (regs_now.move_timeout_ms > 24) ? 24 : regs_now.move_timeout_ms;
    repeat ($urandom_range(0, 3)) put(noise_item(rbit(), 1'b0));
    it = noise_item(1'b1, 1'b0);
    if ($urandom_range(0, 3) == 0) begin
      it.cmd = 1'b0;
      it.button_pressed = 1'b1;
    end else begin
      it.cmd = 1'b1;
      if (it.has_seconds && big_mix) it.start_seconds = 8'd0;
    end
    put(it);
    repeat ($urandom_range(0, span + 2)) put(noise_item(1'b0, 1'b0));
    put(noise_item(($urandom_range(0, 7) == 0), 1'b1));
    repeat ($urandom_range(0, 14)) put(noise_item(rbit(), rbit()));
    repeat ($urandom_range(0, span + 2)) put(noise_item(1'b0, 1'b0));
    put(noise_item(1'b1, 1'b0));
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned base;
    bit paused;
    base = queued;
    paused = 1'b0;
    while (queued - base < n) begin
      if (!paused && queued - base >= n / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(3, 12)) put(noise_item(rbit(), rbit()));
      else add_run();
    end
  endtask

  initial begin
    regs_now = '{MIN_MIX_RST, MAX_MIX_RST, DEFAULT_MIX_RST, TIMEOUT_RST};
    lift_phase = PH_IDLE;
    cycle_busy = 1'b0;
    cycle_err = 1'b0;
    phase_ticks = '0;
    mix_len = MIX_DUR_RST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    set_config(16'd2, 16'd6, 16'd4, 16'd5);
    put(mk(0, 0, 8'h00, 0, 0, 0));
    put(mk(0, 1, 8'hFF, 1, 0, 0));
    put(mk(1, 1, 8'hFF, 1, 0, 0));   // seconds clamp to max
    put(mk(1, 0, 8'h00, 0, 0, 1));   // ignored while busy
    put(mk(0, 0, 8'h00, 0, 0, 0));
    put(mk(0, 0, 8'h00, 1, 1, 0));   // both endstops
    repeat (7) put(mk(0, 0, 8'h00, 0, 0, 0));
    put(mk(0, 0, 8'h00, 1, 0, 0));
    put(mk(0, 0, 8'h00, 1, 0, 1));   // button start
    repeat (7) put(mk(0, 0, 8'h00, 0, 0, 0));   // lowering times out
    put(mk(1, 1, 8'h00, 1, 0, 0));   // zero seconds clamp to min
    put(mk(0, 0, 8'h00, 0, 1, 0));
    put(mk(0, 0, 8'h00, 0, 0, 0));
    random_phase(175);

    set_config(16'd0, 16'd0, 16'd0, 16'd0);
    random_phase(175);

    calm = 1'b1;
    set_config(16'd9, 16'd3, 16'd5, 16'd12);   // inverted clamp
    random_phase(175);
    calm = 1'b0;

    set_config(16'd0, 16'hFFFF, 16'd3, 16'hFFFF);
    random_phase(175);

    set_config(16'd1, 16'd10, 16'hFFFF, 16'd20);
    random_phase(175);

    set_config(16'($urandom_range(0, 8)), 16'($urandom_range(0, 15)),
               ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 20)) : 16'hFFFF,
               16'($urandom_range(0, 25)));
    random_phase(175);

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
